// ===== hw/rtl/mqmb_pkg.sv =====
// Package for the multi-queue message mailbox: request kinds, status codes,
// store word width and the byte mask helper. No dependencies.
`default_nettype none

package mqmb_pkg;

    // Width of one message store word and of the message size field.
    localparam int STORE_W = 64;
    localparam int MB_W    = 4;

    // Request kinds; the other codes are rejected as invalid.
    localparam logic [2:0] KIND_PING    = 3'd0;
    localparam logic [2:0] KIND_CREATE  = 3'd1;
    localparam logic [2:0] KIND_SEND    = 3'd2;
    localparam logic [2:0] KIND_RECEIVE = 3'd3;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_INVALID   = 3'd3,
        ST_FULL      = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DESC  = 3'b010,
        S_STORE = 3'b100
    } t_state;

    // Mask that covers the low n bytes of a store word; eight or more is all.
    function automatic logic [STORE_W-1:0] byte_mask(input logic [MB_W-1:0] n);
        logic [STORE_W-1:0] m;
        m = '0;
        for (int b = 0; b < STORE_W / 8; b++) begin
            if (MB_W'(b) < n) begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mqmb_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the queue descriptors and the message store. No dependencies.
`default_nettype none

module mqmb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic                                         i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/multi_queue_message_mailbox_top.sv =====
// Multi-queue message mailbox top level: request sequencer, descriptor RAM and
// message store RAM. Depends on mqmb_pkg and mqmb_ram.
//
// Usage: one request channel (i_valid/o_ready) carries ping, create, send and
// receive requests; one result channel (o_valid/i_ready) returns exactly one
// result per request, in request order.
// A request is taken only while the sequencer is idle, and first passes the
// descriptor step (S_DESC), which evaluates it against the queue descriptor read
// at acceptance. Ping, create and every rejected request finish there; a
// successful send or receive goes on to the store step (S_STORE), where a send
// does the read-modify-write of its message store word and a receive returns
// the word read from the store. A new request can be taken in the cycle the
// result appears, but never before the last request is finished.
// Reset: synchronous, active low. It clears the sequencer, the result valid and
// the created queue count. No clearing pass runs: descriptors of queues not yet
// created are never used, and each queue tracks whether its write pointer has
// wrapped, so store words never written read as zero.
// Stall: a finished result waits in the output register while i_ready is low;
// the sequencer keeps working and holds only when its next result has no room.
`default_nettype none

module multi_queue_message_mailbox_top #(
    parameter int NUM_QUEUES = 16,
    parameter int MAX_DEPTH  = 64,
    parameter int MSG_BYTES  = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Request channel.
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [2:0]                   i_kind,
    input  wire logic [31:0]                  i_tag,
    input  wire logic [7:0]                   i_queue_id,
    input  wire logic [9:0]                   i_depth_req,
    input  wire logic [7:0]                   i_slot_bytes,
    input  wire logic [mqmb_pkg::STORE_W-1:0] i_payload,
    input  wire logic [7:0]                   i_length,
    // Result channel.
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [31:0]                  o_tag_out,
    output logic      [2:0]                   o_status,
    output logic      [7:0]                   o_value,
    output logic      [mqmb_pkg::STORE_W-1:0] o_payload_out,
    output logic      [7:0]                   o_length_out
);

    import mqmb_pkg::*;

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CW = $clog2(NUM_QUEUES + 1);
    localparam int PW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int SD = NUM_QUEUES * MAX_DEPTH;
    localparam int AW = (SD > 1) ? $clog2(SD) : 1;

    localparam logic [9:0]    MAX_DEPTH_L = 10'(MAX_DEPTH);
    localparam logic [7:0]    MSG_BYTES_L = 8'(MSG_BYTES);
    localparam logic [CW-1:0] NUM_Q_L     = CW'(NUM_QUEUES);
    localparam logic [AW-1:0] MD_A        = AW'(MAX_DEPTH);

    // One queue descriptor as held in the descriptor RAM.
    typedef struct packed {
        logic [DW-1:0]   depth;
        logic [MB_W-1:0] msg_bytes;
        logic [PW-1:0]   rptr;
        logic [PW-1:0]   wptr;
        logic [DW-1:0]   count;
        logic            wrapped;
    } t_desc;

    localparam int DESC_W = $bits(t_desc);

    // Sequencer and request registers.
    t_state             r_state, n_state;
    logic [CW-1:0]      r_made;
    logic [2:0]         r_kind;
    logic [31:0]        r_tag;
    logic [7:0]         r_qid;
    logic [9:0]         r_depth_req;
    logic [7:0]         r_slot_bytes;
    logic [STORE_W-1:0] r_payload;
    logic [7:0]         r_length;
    logic [MB_W-1:0]    r_mb;
    logic               r_old_ok;

    // Output register.
    logic               r_out_valid;
    logic [31:0]        r_tag_out;
    t_status            r_status;
    logic [7:0]         r_value;
    logic [STORE_W-1:0] r_payload_out;
    logic [7:0]         r_length_out;

    // Memory ports.
    logic               desc_we;
    logic [QW-1:0]      desc_waddr;
    t_desc              n_desc;
    t_desc              desc_rd;
    logic [DESC_W-1:0]  desc_rdata;
    logic               desc_re;
    logic [QW-1:0]      desc_raddr;
    logic               store_we;
    logic               store_re;
    logic [AW-1:0]      store_raddr;
    logic [AW-1:0]      store_waddr;
    logic [STORE_W-1:0] store_wdata;
    logic [STORE_W-1:0] store_rdata;

    // Result and control.
    logic               out_free;
    logic               fin;
    t_status            res_status;
    logic [7:0]         res_value;
    logic [STORE_W-1:0] res_payload;
    logic [7:0]         res_length;
    logic               n_made_inc;
    logic               accept;
    logic               found;
    logic [AW-1:0]      base;
    logic [AW-1:0]      r_store_addr;
    logic [STORE_W-1:0] old_word;
    logic [STORE_W-1:0] len_mask;

    assign desc_rd  = t_desc'(desc_rdata);
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;

    // Descriptor read for the addressed queue at acceptance.
    assign desc_re    = accept;
    assign desc_raddr = QW'(i_queue_id - 8'd1);

    // The queue exists when its id is nonzero and not above the created count.
    assign found = (r_qid != 8'd0) && ({1'b0, r_qid} <= 9'(r_made));
    assign base  = AW'(r_qid - 8'd1) * MD_A;

    // Request evaluation against the descriptor, and result selection.
    always_comb begin
        logic [PW-1:0] nxt;
        n_state     = r_state;
        fin         = 1'b0;
        res_status  = ST_OK;
        res_value   = '0;
        res_payload = '0;
        res_length  = '0;
        desc_we     = 1'b0;
        desc_waddr  = QW'(r_qid - 8'd1);
        n_desc      = desc_rd;
        n_made_inc  = 1'b0;
        store_re    = 1'b0;
        store_raddr = base + AW'(desc_rd.rptr);
        store_we    = 1'b0;
        store_wdata = '0;
        nxt         = '0;
        old_word    = r_old_ok ? store_rdata : '0;
        len_mask    = byte_mask(r_length[MB_W-1:0]);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DESC;
                end
            end
            S_DESC: begin
                case (r_kind)
                    KIND_PING: begin
                        res_value = 8'd1;
                        fin       = out_free;
                    end
                    KIND_CREATE: begin
                        fin = out_free;
                        if (r_made >= NUM_Q_L) begin
                            res_status = ST_NO_SPACE;
                        end else if (r_depth_req == 10'd0 || r_depth_req > MAX_DEPTH_L ||
                                     r_slot_bytes > MSG_BYTES_L) begin
                            res_status = ST_INVALID;
                        end else begin
                            res_value         = 8'(r_made) + 8'd1;
                            desc_we           = out_free;
                            desc_waddr        = QW'(r_made);
                            n_desc.depth      = DW'(r_depth_req);
                            n_desc.msg_bytes  = MB_W'(r_slot_bytes);
                            n_desc.rptr       = '0;
                            n_desc.wptr       = '0;
                            n_desc.count      = '0;
                            n_desc.wrapped    = 1'b0;
                            n_made_inc        = out_free;
                        end
                    end
                    KIND_SEND: begin
                        if (!found) begin
                            res_status = ST_NOT_FOUND;
                            fin        = out_free;
                        end else if (r_length > 8'(desc_rd.msg_bytes)) begin
                            res_status = ST_INVALID;
                            fin        = out_free;
                        end else if (desc_rd.count >= desc_rd.depth) begin
                            res_status = ST_FULL;
                            fin        = out_free;
                        end else begin
                            nxt = desc_rd.wptr + PW'(1);
                            store_re    = 1'b1;
                            store_raddr = base + AW'(desc_rd.wptr);
                            desc_we     = 1'b1;
                            if (DW'(desc_rd.wptr) + DW'(1) == desc_rd.depth) begin
                                n_desc.wptr    = '0;
                                n_desc.wrapped = 1'b1;
                            end else begin
                                n_desc.wptr = nxt;
                            end
                            n_desc.count = desc_rd.count + DW'(1);
                            n_state      = S_STORE;
                        end
                    end
                    KIND_RECEIVE: begin
                        if (!found) begin
                            res_status = ST_NOT_FOUND;
                            fin        = out_free;
                        end else if (desc_rd.count == '0) begin
                            res_status = ST_EMPTY;
                            fin        = out_free;
                        end else begin
                            nxt      = desc_rd.rptr + PW'(1);
                            store_re = 1'b1;
                            desc_we  = 1'b1;
                            if (DW'(desc_rd.rptr) + DW'(1) == desc_rd.depth) begin
                                n_desc.rptr = '0;
                            end else begin
                                n_desc.rptr = nxt;
                            end
                            n_desc.count = desc_rd.count - DW'(1);
                            n_state      = S_STORE;
                        end
                    end
                    default: begin
                        res_status = ST_INVALID;
                        fin        = out_free;
                    end
                endcase
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            S_STORE: begin
                if (out_free) begin
                    fin     = 1'b1;
                    n_state = S_IDLE;
                    if (r_kind == KIND_SEND) begin
                        store_we    = 1'b1;
                        store_wdata = (old_word & ~len_mask) | (r_payload & len_mask);
                    end else begin
                        res_payload = store_rdata & byte_mask(r_mb);
                        res_length  = 8'(r_mb);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign store_waddr = r_store_addr;

    // Sequencer state and created queue count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_made  <= '0;
        end else begin
            r_state <= n_state;
            if (n_made_inc) begin
                r_made <= r_made + CW'(1);
            end
        end
    end

    // Request capture at acceptance.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind       <= i_kind;
            r_tag        <= i_tag;
            r_qid        <= i_queue_id;
            r_depth_req  <= i_depth_req;
            r_slot_bytes <= i_slot_bytes;
            r_payload    <= i_payload;
            r_length     <= i_length;
        end
    end

    // Descriptor facts kept for the store step.
    always_ff @(posedge i_clk) begin
        if (store_re) begin
            r_mb         <= desc_rd.msg_bytes;
            r_old_ok     <= desc_rd.wrapped;
            r_store_addr <= store_raddr;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_tag_out     <= r_tag;
            r_status      <= res_status;
            r_value       <= res_value;
            r_payload_out <= res_payload;
            r_length_out  <= res_length;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_tag_out     = r_tag_out;
    assign o_status      = r_status;
    assign o_value       = r_value;
    assign o_payload_out = r_payload_out;
    assign o_length_out  = r_length_out;

    // Queue descriptor memory.
    mqmb_ram #(
        .WIDTH (DESC_W),
        .DEPTH (NUM_QUEUES)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (desc_we),
        .i_waddr (desc_waddr),
        .i_wdata (DESC_W'(n_desc)),
        .i_re    (desc_re),
        .i_raddr (desc_raddr),
        .o_rdata (desc_rdata)
    );

    // Shared message store, MAX_DEPTH words per queue.
    mqmb_ram #(
        .WIDTH (STORE_W),
        .DEPTH (SD)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (store_wdata),
        .i_re    (store_re),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

`ifndef SYNTHESIS
    // The created queue count never passes the number of queues.
    a_made_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_made <= NUM_Q_L)
        else $error("created queue count out of range");

    // A finished result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !fin)
        else $error("result overwritten while stalled");

    // A descriptor write never holds more messages than the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        desc_we |-> (n_desc.count <= n_desc.depth))
        else $error("queue fill count above depth");

    // An accepted request always moves to the descriptor step next.
    a_accept_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DESC))
        else $error("accepted request not evaluated");
`endif

endmodule

`default_nettype wire
